/* src/deq_pkg.sv */
package deq_pkg;

    // Command codes carried in the input beat
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_BACK   = 3'd3;
    localparam logic [2:0] CMD_READ_ALL   = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data;
        logic               last;
    } t_out_item;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_WALK_FIRST,
        OP_WALK_NEXT
    } t_dp_op;

    typedef enum logic [1:0] {
        OUT_HOLD,
        OUT_STATUS,
        OUT_WORD
    } t_out_sel;

    typedef struct packed {
        t_dp_op     op;
        t_out_sel   out_sel;
        logic [1:0] status;
        logic       last;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic walk_last;
    } t_dp_stat;

endpackage

/* src/double_ended_queue_top.sv */
// Channel   Direction  Handshake                 Beat
// input     in         i_in_valid / o_in_ready   i_in_item  (cmd, value)
// output    out        o_out_valid / i_out_ready o_out_item (status, data, last)
//
// One command at a time. A push, a full push and any empty result go straight
// to the result register; a pop first passes through the registered read of
// the entry memory. A read-all reads the front entry on acceptance and then
// moves each entry by a memory read, then an output beat; output stalls hold it.
// Reset clears the front pointer and the count; entries are not cleared.
// o_in_ready is low from acceptance of a known command until the last result beat is taken.
module double_ended_queue_top #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  deq_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output deq_pkg::t_out_item o_out_item
);

    deq_pkg::t_dp_cmd  w_dp_cmd;
    deq_pkg::t_dp_stat w_dp_stat;

    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cmd       (i_in_item.cmd),
        .i_out_ready (i_out_ready),
        .i_dp_stat   (w_dp_stat),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_dp_cmd    (w_dp_cmd)
    );

    deq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_dp_cmd   (w_dp_cmd),
        .i_value    (i_in_item.value),
        .o_dp_stat  (w_dp_stat),
        .o_out_item (o_out_item)
    );

endmodule

/* src/deq_dp.sv */
module deq_dp #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  deq_pkg::t_dp_cmd   i_dp_cmd,
    input  logic signed [31:0] i_value,
    output deq_pkg::t_dp_stat  o_dp_stat,
    output deq_pkg::t_out_item o_out_item
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW:0]   DEPTH_W = (CW + 1)'(DEPTH);
    localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] r_rd_data;
    deq_pkg::t_out_item r_out;

    logic [IW-1:0] r_front, n_front;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_slot, n_slot;
    logic [CW-1:0] r_left, n_left;

    logic [CW:0]   w_back_sum, w_back_wrap, w_tail_sum, w_tail_wrap;
    logic [IW-1:0] w_back_slot, w_tail_slot;
    logic [IW-1:0] w_front_prev, w_front_next, w_slot_next;
    logic          w_we, w_re;
    logic [IW-1:0] w_waddr, w_raddr;

    // front + count stays below twice the depth: one compare and subtract wraps it
    assign w_back_sum  = (CW + 1)'(r_front) + (CW + 1)'(r_count);
    assign w_back_wrap = (w_back_sum >= DEPTH_W) ? w_back_sum - DEPTH_W : w_back_sum;
    assign w_back_slot = w_back_wrap[IW-1:0];
    assign w_tail_sum  = w_back_sum - (CW + 1)'(1);
    assign w_tail_wrap = (w_tail_sum >= DEPTH_W) ? w_tail_sum - DEPTH_W : w_tail_sum;
    assign w_tail_slot = w_tail_wrap[IW-1:0];

    assign w_front_prev = (r_front == '0) ? LAST_SLOT : r_front - IW'(1);
    assign w_front_next = (r_front == LAST_SLOT) ? '0 : r_front + IW'(1);
    assign w_slot_next  = (r_slot == LAST_SLOT) ? '0 : r_slot + IW'(1);

    always_comb begin
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_waddr = w_back_slot;
        w_raddr = r_front;
        n_front = r_front;
        n_count = r_count;
        n_slot  = r_slot;
        n_left  = r_left;
        unique case (i_dp_cmd.op)
            deq_pkg::OP_PUSH_FRONT: begin
                w_we    = 1'b1;
                w_waddr = w_front_prev;
                n_front = w_front_prev;
                n_count = r_count + CW'(1);
            end
            deq_pkg::OP_PUSH_BACK: begin
                w_we    = 1'b1;
                w_waddr = w_back_slot;
                n_count = r_count + CW'(1);
            end
            deq_pkg::OP_POP_FRONT: begin
                w_re    = 1'b1;
                w_raddr = r_front;
                n_front = w_front_next;
                n_count = r_count - CW'(1);
            end
            deq_pkg::OP_POP_BACK: begin
                w_re    = 1'b1;
                w_raddr = w_tail_slot;
                n_count = r_count - CW'(1);
            end
            deq_pkg::OP_WALK_FIRST: begin
                w_re    = 1'b1;
                w_raddr = r_front;
                n_slot  = w_front_next;
                n_left  = r_count;
            end
            deq_pkg::OP_WALK_NEXT: begin
                w_re    = 1'b1;
                w_raddr = r_slot;
                n_slot  = w_slot_next;
                n_left  = r_left - CW'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
            r_slot  <= '0;
            r_left  <= '0;
        end else begin
            r_front <= n_front;
            r_count <= n_count;
            r_slot  <= n_slot;
            r_left  <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= i_value;
        end
        if (w_re) begin
            r_rd_data <= mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_dp_cmd.out_sel)
            deq_pkg::OUT_STATUS: begin
                r_out.status <= i_dp_cmd.status;
                r_out.data   <= '0;
                r_out.last   <= 1'b1;
            end
            deq_pkg::OUT_WORD: begin
                r_out.status <= deq_pkg::ST_OK;
                r_out.data   <= r_rd_data;
                r_out.last   <= i_dp_cmd.last;
            end
            default: begin
            end
        endcase
    end

    assign o_dp_stat.full      = (r_count == CW'(DEPTH));
    assign o_dp_stat.empty     = (r_count == '0);
    assign o_dp_stat.walk_last = (r_left == CW'(1));
    assign o_out_item          = r_out;

endmodule

/* src/deq_ctrl.sv */
module deq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [2:0]        i_cmd,
    input  logic              i_out_ready,
    input  deq_pkg::t_dp_stat i_dp_stat,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output deq_pkg::t_dp_cmd  o_dp_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SEND
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   r_walking, n_walking;
    logic   r_more, n_more;
    logic   w_in_fire;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_dp_cmd.op      = deq_pkg::OP_NONE;
        o_dp_cmd.out_sel = deq_pkg::OUT_HOLD;
        o_dp_cmd.status  = deq_pkg::ST_OK;
        o_dp_cmd.last    = 1'b1;
        n_state          = r_state;
        n_out_valid      = r_out_valid;
        n_walking        = r_walking;
        n_more           = r_more;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    unique case (i_cmd)
                        deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK: begin
                            o_dp_cmd.out_sel = deq_pkg::OUT_STATUS;
                            n_state          = S_SEND;
                            n_out_valid      = 1'b1;
                            n_more           = 1'b0;
                            if (i_dp_stat.full) begin
                                o_dp_cmd.status = deq_pkg::ST_FULL;
                            end else begin
                                o_dp_cmd.op = (i_cmd == deq_pkg::CMD_PUSH_FRONT)
                                            ? deq_pkg::OP_PUSH_FRONT
                                            : deq_pkg::OP_PUSH_BACK;
                            end
                        end
                        deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_BACK,
                        deq_pkg::CMD_READ_ALL: begin
                            if (i_dp_stat.empty) begin
                                o_dp_cmd.out_sel = deq_pkg::OUT_STATUS;
                                o_dp_cmd.status  = deq_pkg::ST_EMPTY;
                                n_state          = S_SEND;
                                n_out_valid      = 1'b1;
                                n_more           = 1'b0;
                            end else begin
                                priority case (i_cmd)
                                    deq_pkg::CMD_POP_FRONT: o_dp_cmd.op = deq_pkg::OP_POP_FRONT;
                                    deq_pkg::CMD_POP_BACK:  o_dp_cmd.op = deq_pkg::OP_POP_BACK;
                                    default:                o_dp_cmd.op = deq_pkg::OP_WALK_FIRST;
                                endcase
                                n_walking = (i_cmd == deq_pkg::CMD_READ_ALL);
                                n_state   = S_READ;
                            end
                        end
                        default: begin
                            // unused codes: drop the beat
                        end
                    endcase
                end
            end
            S_READ: begin
                o_dp_cmd.out_sel = deq_pkg::OUT_WORD;
                o_dp_cmd.last    = r_walking ? i_dp_stat.walk_last : 1'b1;
                n_more           = r_walking && !i_dp_stat.walk_last;
                n_state          = S_SEND;
                n_out_valid      = 1'b1;
            end
            S_SEND: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    if (r_more) begin
                        o_dp_cmd.op = deq_pkg::OP_WALK_NEXT;
                        n_state     = S_READ;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_walking   <= 1'b0;
            r_more      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_walking   <= n_walking;
            r_more      <= n_more;
        end
    end

endmodule

/* src/deq_chk.sv */
module deq_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input deq_pkg::t_in_item  i_in_item,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input deq_pkg::t_out_item o_out_item
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result beat changed while stalled");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input taken while a result is pending");

    a_push_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready &&
        (i_in_item.cmd == deq_pkg::CMD_PUSH_FRONT ||
         i_in_item.cmd == deq_pkg::CMD_PUSH_BACK) |=> o_out_valid)
        else $error("push did not produce a result next cycle");

    a_flag_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != deq_pkg::ST_OK |->
        o_out_item.last && o_out_item.data == '0)
        else $error("empty or full result not a single zero beat");

endmodule

bind double_ended_queue_top deq_chk u_deq_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

/* tb/deq_shadow_check.sv */
`timescale 1ns / 100ps

module deq_shadow_check #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  deq_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  deq_pkg::t_out_item i_out_item,
    output int                 o_mismatches,
    output int                 o_outstanding
);

    logic signed [31:0] shadow_words [DEPTH];
    int                 shadow_front;
    int                 shadow_count;
    deq_pkg::t_out_item expected_beats [$];

    // Advance the shadow deque by one command and queue the beats it yields.
    task automatic apply_command(input deq_pkg::t_in_item cmd_beat);
        deq_pkg::t_out_item res;
        int                 i;
        res      = '0;
        res.last = 1'b1;
        case (cmd_beat.cmd)
            deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK: begin
                if (shadow_count >= DEPTH) begin
                    res.status = deq_pkg::ST_FULL;
                end else if (cmd_beat.cmd == deq_pkg::CMD_PUSH_FRONT) begin
                    shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
                    shadow_words[shadow_front] = cmd_beat.value;
                    shadow_count++;
                end else begin
                    shadow_words[(shadow_front + shadow_count) % DEPTH] = cmd_beat.value;
                    shadow_count++;
                end
                expected_beats.push_back(res);
            end
            deq_pkg::CMD_POP_FRONT: begin
                if (shadow_count == 0) begin
                    res.status = deq_pkg::ST_EMPTY;
                end else begin
                    res.data     = shadow_words[shadow_front];
                    shadow_front = (shadow_front + 1) % DEPTH;
                    shadow_count--;
                end
                expected_beats.push_back(res);
            end
            deq_pkg::CMD_POP_BACK: begin
                if (shadow_count == 0) begin
                    res.status = deq_pkg::ST_EMPTY;
                end else begin
                    res.data = shadow_words[(shadow_front + shadow_count - 1) % DEPTH];
                    shadow_count--;
                end
                expected_beats.push_back(res);
            end
            deq_pkg::CMD_READ_ALL: begin
                if (shadow_count == 0) begin
                    res.status = deq_pkg::ST_EMPTY;
                    expected_beats.push_back(res);
                end else begin
                    for (i = 0; i < shadow_count; i++) begin
                        res.status = deq_pkg::ST_OK;
                        res.data   = shadow_words[(shadow_front + i) % DEPTH];
                        res.last   = (i == shadow_count - 1);
                        expected_beats.push_back(res);
                    end
                end
            end
            default: ;  // unused codes: drop silently
        endcase
    endtask

    always @(posedge i_clk) begin
        deq_pkg::t_out_item want;
        if (!i_rst_n) begin
            shadow_front = 0;
            shadow_count = 0;
            o_mismatches = 0;
            expected_beats.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                apply_command(i_in_item);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_beats.size() == 0) begin
                    $error("unexpected result beat: status %0d data %0d last %0d",
                           i_out_item.status, i_out_item.data, i_out_item.last);
                    o_mismatches++;
                end else begin
                    want = expected_beats.pop_front();
                    if (i_out_item.status !== want.status) begin
                        $error("status: expected %0d, got %0d",
                               want.status, i_out_item.status);
                        o_mismatches++;
                    end
                    if (i_out_item.data !== want.data) begin
                        $error("data: expected %0d, got %0d", want.data, i_out_item.data);
                        o_mismatches++;
                    end
                    if (i_out_item.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, i_out_item.last);
                        o_mismatches++;
                    end
                end
            end
        end
        o_outstanding = expected_beats.size();
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;

    localparam int DEPTH      = 16;
    localparam int IDLE_LIMIT = 5000;
    localparam int RAND_ITEMS = 75;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    deq_pkg::t_in_item  in_item   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    deq_pkg::t_out_item out_item;

    int mismatches;
    int outstanding;
    int idle_cycles = 0;
    bit steady      = 1'b0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    double_ended_queue_top #(.DEPTH(DEPTH)) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    deq_shadow_check #(.DEPTH(DEPTH)) checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .o_mismatches (mismatches),
        .o_outstanding(outstanding)
    );

    // Abort if neither channel moves a beat for too long.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: drop ready for a random stall before taking each result beat; steady mode does not stall.
    initial begin
        int stall;
        forever begin
            stall = steady ? 0 : $urandom_range(0, 3);
            repeat (stall) begin
                @(negedge clk);
                out_ready <= 1'b0;
            end
            @(negedge clk);
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    task automatic send_cmd(input logic [2:0] cmd, input logic signed [31:0] value);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid      <= 1'b1;
        in_item.cmd   <= cmd;
        in_item.value <= value;
        do @(posedge clk); while (!(in_valid && in_ready));
    endtask

    // Drop valid and hold until every expected beat has come back.
    task automatic hold_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    function automatic logic signed [31:0] pick_word();
        logic signed [31:0] w;
        case ($urandom_range(0, 11))
            0:       w = 32'sh8000_0000;
            1:       w = 32'sh7fff_ffff;
            2:       w = 32'sd0;
            3:       w = -32'sd1;
            default: w = $urandom;
        endcase
        return w;
    endfunction

    // fill_bias sets the percent of push and pop commands that push
    function automatic logic [2:0] pick_cmd(input int fill_bias);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            return 3'($urandom_range(5, 7));
        if (roll < 14)
            return deq_pkg::CMD_READ_ALL;
        if ($urandom_range(0, 99) < fill_bias)
            return $urandom_range(0, 1) ? deq_pkg::CMD_PUSH_FRONT : deq_pkg::CMD_PUSH_BACK;
        return $urandom_range(0, 1) ? deq_pkg::CMD_POP_FRONT : deq_pkg::CMD_POP_BACK;
    endfunction

    initial begin
        int         i;
        int         issued;
        int         segment;
        int         bias;
        logic [2:0] cmd;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty queue on every reading command
        send_cmd(deq_pkg::CMD_POP_FRONT, 32'sd5);
        send_cmd(deq_pkg::CMD_POP_BACK, -32'sd5);
        send_cmd(deq_pkg::CMD_READ_ALL, 32'sd0);
        // fill from both ends, extremes first
        for (i = 0; i < DEPTH; i++) begin
            case (i)
                0:       send_cmd(deq_pkg::CMD_PUSH_FRONT, 32'sh8000_0000);
                1:       send_cmd(deq_pkg::CMD_PUSH_BACK, 32'sh7fff_ffff);
                2:       send_cmd(deq_pkg::CMD_PUSH_FRONT, 32'sd0);
                3:       send_cmd(deq_pkg::CMD_PUSH_BACK, -32'sd1);
                default: send_cmd((i % 2) ? deq_pkg::CMD_PUSH_BACK : deq_pkg::CMD_PUSH_FRONT,
                                  $urandom);
            endcase
        end
        send_cmd(deq_pkg::CMD_PUSH_FRONT, 32'sh1234_5678);
        send_cmd(deq_pkg::CMD_PUSH_BACK, -32'sd77);
        send_cmd(deq_pkg::CMD_READ_ALL, 32'sd0);
        send_cmd(deq_pkg::CMD_POP_FRONT, 32'sd0);
        send_cmd(deq_pkg::CMD_POP_BACK, 32'sd0);
        send_cmd(3'd5, 32'sh5555_5555);
        send_cmd(3'd6, 32'shAAAA_AAAA);
        send_cmd(3'd7, -32'sd1);
        hold_until_drained();

        issued  = 0;
        segment = 0;
        while (issued < RAND_ITEMS) begin
            case (segment % 4)
                0:       bias = 80;
                1:       bias = 20;
                2:       bias = 55;
                default: bias = 65;
            endcase
            steady = (segment % 4 == 3);
            for (i = 0; i < 20 && issued < RAND_ITEMS; i++) begin
                cmd = pick_cmd(bias);
                send_cmd(cmd, pick_word());
                if (cmd <= deq_pkg::CMD_READ_ALL)
                    issued++;
            end
            if (segment % 2 == 1)
                hold_until_drained();
            segment++;
        end
        steady = 1'b0;

        hold_until_drained();
        repeat (40) @(negedge clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
